FILE: rtl/core/top_two_margin_confidence_assert.svh
// Assertion macros for the top-two margin confidence block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TOP_TWO_MARGIN_CONFIDENCE_ASSERT_SVH
`define TOP_TWO_MARGIN_CONFIDENCE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define TMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tmc: check failed");
// Next-cycle implication.
`define TMC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tmc: check failed");
`else
`define TMC_ASSERT_IMP(lbl, ante, cons)
`define TMC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/tmc_pkg.sv
package tmc_pkg;

  // Default sizes
  localparam int MAX_ROW_LENGTH_DEF  = 4096;
  localparam int MAX_ROWS_DEF        = 65535;
  localparam int EXP_TABLE_DEPTH_DEF = 1024;

  // Field and register widths
  localparam int SCORE_W    = 24;
  localparam int THR_W      = 24;
  localparam int RL_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int MARGIN_W   = 25;
  localparam int MEAN_CNT_W = 20;
  localparam int ROWS_W     = 16;
  localparam int OUT_W      = 64;
  localparam int EXP_W      = 33;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd2;

  // Mode codes
  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_MIN = 1'b1;

  // Fixed-point constants of the compared values
  localparam logic signed [SCORE_W+1:0] VAL_ONE   = 26'sd65536;
  localparam logic signed [SCORE_W+1:0] VAL_FLOOR = -26'sd8388608;

  // Q32 ratio between neighbouring table entries, from a truncated Taylor series
  function automatic logic [31:0] exp_step(input logic [63:0] h);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1 << 32;
    sum  = 64'd1 << 32;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * h) >> 32) / 64'(n);
      if (n[0]) sum = sum - term;
      else sum = sum + term;
    end
    return sum[31:0];
  endfunction

endpackage

FILE: rtl/core/tmc_div.sv
module tmc_div
  import tmc_pkg::*;
#(
  parameter int NW = 24,
  parameter int DW = 33
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_q, q_d;
  logic [DW-1:0] r_q, r_d;
  logic [DW-1:0] den_q, den_d;
  logic [CW-1:0] n_q, n_d;
  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [DW:0]   trial;
  logic          ge;

  // One quotient bit per cycle, restoring form
  always_comb begin
    trial  = {r_q, q_q[NW-1]};
    ge     = trial >= {1'b0, den_q};
    q_d    = q_q;
    r_d    = r_q;
    den_d  = den_q;
    n_d    = n_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      q_d   = num_i;
      r_d   = rem_i;
      den_d = den_i;
      n_d   = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      q_d = {q_q[NW-2:0], ge};
      r_d = ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);
      n_d = n_q + 1'b1;
      if (n_q == CW'(NW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      n_q    <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      n_q    <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    r_q   <= r_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

FILE: rtl/core/tmc_exp_rom.sv
module tmc_exp_rom
  import tmc_pkg::*;
#(
  parameter int DEPTH = EXP_TABLE_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [EXP_W-1:0]         rd_data_o,
  output logic                     ready_o
);

  localparam int          AW   = $clog2(DEPTH);
  localparam int          KW   = $clog2(DEPTH + 1);
  localparam logic [63:0] H    = (64'd1 << 36) / DEPTH;
  localparam logic [31:0] STEP = exp_step(H);

  logic [EXP_W-1:0] mem [DEPTH];
  logic [EXP_W-1:0] rd_q;

  logic [KW-1:0]    k_q, k_d;
  logic             ph_q, ph_d;
  logic             rdy_q, rdy_d;
  logic [31:0]      prev_q, prev_d;
  logic [63:0]      prod_q, prod_d;
  logic [63:0]      rnd;
  logic             we;
  logic [EXP_W-1:0] wd;

  // Fill sweep: entry 0 is one, each later entry is the previous one times the step, rounded
  always_comb begin
    k_d    = k_q;
    ph_d   = ph_q;
    rdy_d  = rdy_q;
    prev_d = prev_q;
    prod_d = prod_q;
    we     = 1'b0;
    wd     = '0;
    rnd    = prod_q + 64'h8000_0000;
    if (!rdy_q) begin
      if (k_q == '0) begin
        we  = 1'b1;
        wd  = 33'h1_0000_0000;
        k_d = k_q + 1'b1;
      end else if (k_q == KW'(1)) begin
        we     = 1'b1;
        wd     = {1'b0, STEP};
        prev_d = STEP;
        k_d    = k_q + 1'b1;
      end else if (!ph_q) begin
        prod_d = prev_q * STEP;
        ph_d   = 1'b1;
      end else begin
        we     = 1'b1;
        wd     = {1'b0, rnd[63:32]};
        prev_d = rnd[63:32];
        ph_d   = 1'b0;
        k_d    = k_q + 1'b1;
      end
      if (we && k_q == KW'(DEPTH - 1)) rdy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= '0;
      ph_q  <= 1'b0;
      rdy_q <= 1'b0;
    end else begin
      k_q   <= k_d;
      ph_q  <= ph_d;
      rdy_q <= rdy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    prod_q <= prod_d;
  end

  // Table storage, registered read
  always_ff @(posedge clk_i) begin
    if (we) mem[k_q[AW-1:0]] <= wd;
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;
  assign ready_o   = rdy_q;

endmodule

FILE: rtl/core/tmc_row_mem.sv
module tmc_row_mem
  import tmc_pkg::*;
#(
  parameter int DEPTH = MAX_ROW_LENGTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [SCORE_W-1:0]       wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [SCORE_W-1:0]       rdata_o
);

  logic [SCORE_W-1:0] mem [DEPTH];
  logic [SCORE_W-1:0] rd_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rd_q <= mem[raddr_i];
  end

  assign rdata_o = rd_q;

endmodule

FILE: rtl/core/top_two_margin_confidence.sv
// Top-two margin confidence: each score item passes the convert and update states; in max
// mode the table lookup comes between them, unless the score lies beyond the table, and
// a score >= 0 may also pass the divider. A completed row adds a counting pass over the row
// memory. After the last item both means are formed one after the other (shared divider).
// Reset is asynchronous, active low; afterwards the exponent table is filled,
// during which no item is taken.
`include "top_two_margin_confidence_assert.svh"

module top_two_margin_confidence
  import tmc_pkg::*;
#(
  parameter int MAX_ROW_LENGTH  = MAX_ROW_LENGTH_DEF,
  parameter int MAX_ROWS        = MAX_ROWS_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SCORE_W-1:0]    s_axis_tdata,  // [23:0] score
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [24:0] mean_margin, [44:25] mean_near_count, [60:45] rows_seen, [63:61] zero
  output logic [OUT_W-1:0]      m_axis_tdata
);

  localparam int AW   = $clog2(MAX_ROW_LENGTH);
  localparam int LW   = $clog2(MAX_ROW_LENGTH + 1);
  localparam int RCW  = $clog2(MAX_ROWS + 1);
  localparam int TAW  = $clog2(EXP_TABLE_DEPTH);
  localparam int DEPW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PW   = SCORE_W + DEPW;
  localparam int IW   = PW - 20;
  localparam int MSW  = MARGIN_W + RCW;
  localparam int NSW  = LW + RCW;
  localparam int DNW  = (MSW > NSW + 8) ? MSW : NSW + 8;
  localparam int CVW  = 24;

  // Sequencer states
  localparam logic [3:0] ST_FILL = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_CONV = 4'd2;
  localparam logic [3:0] ST_EXP  = 4'd3;
  localparam logic [3:0] ST_DIV  = 4'd4;
  localparam logic [3:0] ST_UPD  = 4'd5;
  localparam logic [3:0] ST_CNT  = 4'd6;
  localparam logic [3:0] ST_RES  = 4'd7;
  localparam logic [3:0] ST_DV1  = 4'd8;
  localparam logic [3:0] ST_DV2  = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  logic [3:0] state_q, state_d;

  // Configuration
  logic              mode_q;
  logic [RL_W-1:0]   rl_q;
  logic [THR_W-1:0]  thr_q;
  logic [LW-1:0]     len;

  // Item and row state
  logic signed [SCORE_W-1:0] score_q, score_d;
  logic                      end_q, end_d;
  logic signed [SCORE_W-1:0] v_q, v_d;
  logic [AW-1:0]             col_q, col_d;
  logic signed [SCORE_W-1:0] best_q, best_d, second_q, second_d;
  logic                      bf_q, bf_d, sf_q, sf_d;
  logic [AW-1:0]             bpos_q, bpos_d;
  logic [MSW-1:0]            msum_q, msum_d;
  logic [NSW-1:0]            nsum_q, nsum_d;
  logic [RCW-1:0]            rows_q, rows_d;
  logic [LW-1:0]             cnt_q, cnt_d;
  logic [LW-1:0]             j_q, j_d;
  logic                      rv_q, rv_d;
  logic [AW-1:0]             rj_q, rj_d;
  logic [MARGIN_W-1:0]       mm_q, mm_d;
  logic [MEAN_CNT_W-1:0]     mn_q, mn_d;
  logic [OUT_W-1:0]          out_q, out_d;
  logic                      mvalid_q, mvalid_d;

  // Memory and divider wiring
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [AW-1:0]        mem_ra;
  logic [SCORE_W-1:0]   mem_rd;
  logic [TAW-1:0]       rom_addr;
  logic [EXP_W-1:0]     rom_rd;
  logic                 rom_rdy;
  logic                 cv_start, cv_done;
  logic [CVW-1:0]       cv_quot;
  logic                 fin_start, fin_done;
  logic [DNW-1:0]       fin_num, fin_quot;

  // Helpers
  logic [SCORE_W-1:0]        xabs;
  logic [PW-1:0]             xprod;
  logic [IW-1:0]             idx;
  logic [EXP_W:0]            erond;
  logic signed [SCORE_W+1:0] vwide;
  logic [LW-1:0]             colx, coln;
  logic signed [SCORE_W+1:0] bref, delta, mgn;
  logic                      near;
  logic [LW-1:0]             cnt_fin;
  logic [63:0]               q64;
  logic [31:0]               rows32;
  logic [ROWS_W-1:0]         rows_sat;
  logic                      out_load;
  logic                      clr_row;

  // Effective row length, clamped to 2..MAX_ROW_LENGTH
  always_comb begin
    if (32'(rl_q) < 32'd2) len = LW'(2);
    else if (32'(rl_q) > 32'(MAX_ROW_LENGTH)) len = LW'(MAX_ROW_LENGTH);
    else len = LW'(rl_q);
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MAX;
      rl_q   <= RL_W'(4096);
      thr_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_MODE:       mode_q <= cfg_data_i[0];
        CFG_ROW_LENGTH: rl_q   <= cfg_data_i[RL_W-1:0];
        CFG_THRESHOLD:  thr_q  <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    score_d   = score_q;
    end_d     = end_q;
    v_d       = v_q;
    col_d     = col_q;
    best_d    = best_q;
    second_d  = second_q;
    bf_d      = bf_q;
    sf_d      = sf_q;
    bpos_d    = bpos_q;
    msum_d    = msum_q;
    nsum_d    = nsum_q;
    rows_d    = rows_q;
    cnt_d     = cnt_q;
    j_d       = j_q;
    rv_d      = rv_q;
    rj_d      = rj_q;
    mm_d      = mm_q;
    mn_d      = mn_q;
    out_d     = out_q;
    mvalid_d  = mvalid_q && !m_axis_tready;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_ra    = j_q[AW-1:0];
    cv_start  = 1'b0;
    fin_start = 1'b0;
    fin_num   = DNW'(msum_q);
    clr_row   = 1'b0;
    out_load  = 1'b0;

    xabs  = score_q[SCORE_W-1] ? (~score_q + 1'b1) : score_q;
    xprod = PW'(xabs) * PW'(EXP_TABLE_DEPTH);
    idx   = xprod[PW-1:20];
    rom_addr = idx[TAW-1:0];
    erond = {1'b0, rom_rd} + (EXP_W+1)'(32768);
    vwide = VAL_ONE - $signed({2'b00, cv_quot});
    colx  = (LW'(col_q) >= len) ? '0 : LW'(col_q);
    coln  = colx + 1'b1;

    bref  = bf_q ? (SCORE_W+2)'(best_q) : '0;
    delta = (mode_q == MODE_MAX) ? bref - (SCORE_W+2)'($signed(mem_rd))
                                 : (SCORE_W+2)'($signed(mem_rd)) - bref;
    near  = !(bf_q && rj_q == bpos_q) && (delta < $signed({2'b00, thr_q}));
    cnt_fin = cnt_q + LW'(near);
    mgn   = (mode_q == MODE_MAX) ? (SCORE_W+2)'(best_q) - (SCORE_W+2)'(second_q)
                                 : (SCORE_W+2)'(second_q) - (SCORE_W+2)'(best_q);

    q64      = 64'(fin_quot);
    rows32   = 32'(rows_q);
    rows_sat = (rows32 > 32'hFFFF) ? 16'hFFFF : rows32[ROWS_W-1:0];

    unique case (state_q)
      ST_FILL: begin
        if (rom_rdy) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          score_d = s_axis_tdata;
          end_d   = s_axis_tlast;
          state_d = ST_CONV;
        end
      end
      // Take the raw score, use a fixed value beyond the table, or look up the exponent
      ST_CONV: begin
        if (mode_q == MODE_MIN) begin
          v_d     = score_q;
          state_d = ST_UPD;
        end else if (idx >= IW'(EXP_TABLE_DEPTH)) begin
          v_d     = score_q[SCORE_W-1] ? SCORE_W'(VAL_ONE) : SCORE_W'(VAL_FLOOR);
          state_d = ST_UPD;
        end else begin
          state_d = ST_EXP;
        end
      end
      ST_EXP: begin
        if (score_q[SCORE_W-1]) begin
          v_d     = SCORE_W'(VAL_ONE - $signed({1'b0, erond[EXP_W:16]}));
          state_d = ST_UPD;
        end else if (rom_rd <= EXP_W'(33'h100_0000)) begin
          v_d     = SCORE_W'(VAL_FLOOR);
          state_d = ST_UPD;
        end else begin
          cv_start = 1'b1;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cv_done) begin
          v_d     = (vwide < VAL_FLOOR) ? SCORE_W'(VAL_FLOOR) : SCORE_W'(vwide);
          state_d = ST_UPD;
        end
      end
      // Store the value and track best and second best
      ST_UPD: begin
        mem_we = 1'b1;
        mem_wa = colx[AW-1:0];
        if (mode_q == MODE_MAX) begin
          if (v_q > best_q) begin
            second_d = best_q;
            best_d   = v_q;
            bpos_d   = colx[AW-1:0];
            bf_d     = 1'b1;
          end else if (v_q > second_q) begin
            second_d = v_q;
          end
        end else begin
          if (!bf_q || v_q < best_q) begin
            if (bf_q) begin
              second_d = best_q;
              sf_d     = 1'b1;
            end
            best_d = v_q;
            bpos_d = colx[AW-1:0];
            bf_d   = 1'b1;
          end else if (!sf_q || v_q < second_q) begin
            second_d = v_q;
            sf_d     = 1'b1;
          end
        end
        if (coln >= len) begin
          j_d     = '0;
          rv_d    = 1'b0;
          cnt_d   = '0;
          state_d = ST_CNT;
        end else begin
          col_d   = coln[AW-1:0];
          state_d = end_q ? ST_RES : ST_IDLE;
        end
      end
      // Counting pass over the stored row
      ST_CNT: begin
        if (j_q < len) begin
          j_d  = j_q + 1'b1;
          rv_d = 1'b1;
          rj_d = j_q[AW-1:0];
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q) begin
          cnt_d = cnt_fin;
          if (LW'(rj_q) == len - 1'b1) begin
            if (rows_q < RCW'(MAX_ROWS)) begin
              rows_d = rows_q + 1'b1;
              msum_d = msum_q + MSW'(mgn[MARGIN_W-1:0]);
              nsum_d = nsum_q + NSW'(cnt_fin);
            end
            rv_d    = 1'b0;
            clr_row = 1'b1;
            state_d = end_q ? ST_RES : ST_IDLE;
          end
        end
      end
      ST_RES: begin
        if (rows_q == '0) begin
          mm_d    = '0;
          mn_d    = '0;
          state_d = ST_OUT;
        end else begin
          fin_start = 1'b1;
          state_d   = ST_DV1;
        end
      end
      ST_DV1: begin
        if (fin_done) begin
          mm_d      = q64[MARGIN_W-1:0];
          fin_num   = DNW'({nsum_q, 8'd0});
          fin_start = 1'b1;
          state_d   = ST_DV2;
        end
      end
      ST_DV2: begin
        if (fin_done) begin
          mn_d    = (q64 > 64'hF_FFFF) ? '1 : q64[MEAN_CNT_W-1:0];
          state_d = ST_OUT;
        end
      end
      // Hand the result to the output register once it is free
      ST_OUT: begin
        if (!mvalid_q || m_axis_tready) begin
          out_load = 1'b1;
          out_d    = {3'd0, rows_sat, mn_q, mm_q};
          mvalid_d = 1'b1;
          msum_d   = '0;
          nsum_d   = '0;
          rows_d   = '0;
          clr_row  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Mode or length change drops the partial row
    if (cfg_we_i && (cfg_addr_i == CFG_MODE || cfg_addr_i == CFG_ROW_LENGTH)) begin
      clr_row = 1'b1;
    end
    if (clr_row) begin
      col_d    = '0;
      best_d   = '0;
      second_d = '0;
      bf_d     = 1'b0;
      sf_d     = 1'b0;
      bpos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_FILL;
      col_q    <= '0;
      best_q   <= '0;
      second_q <= '0;
      bf_q     <= 1'b0;
      sf_q     <= 1'b0;
      bpos_q   <= '0;
      msum_q   <= '0;
      nsum_q   <= '0;
      rows_q   <= '0;
      rv_q     <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      best_q   <= best_d;
      second_q <= second_d;
      bf_q     <= bf_d;
      sf_q     <= sf_d;
      bpos_q   <= bpos_d;
      msum_q   <= msum_d;
      nsum_q   <= nsum_d;
      rows_q   <= rows_d;
      rv_q     <= rv_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    end_q   <= end_d;
    v_q     <= v_d;
    cnt_q   <= cnt_d;
    j_q     <= j_d;
    rj_q    <= rj_d;
    mm_q    <= mm_d;
    mn_q    <= mn_d;
    out_q   <= out_d;
  end

  tmc_row_mem #(
    .DEPTH(MAX_ROW_LENGTH)
  ) u_row_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_wa),
    .wdata_i(v_q),
    .raddr_i(mem_ra),
    .rdata_o(mem_rd)
  );

  tmc_exp_rom #(
    .DEPTH(EXP_TABLE_DEPTH)
  ) u_exp_rom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(rom_addr),
    .rd_data_o(rom_rd),
    .ready_o  (rom_rdy)
  );

  // Reciprocal of the table entry: 2^24 * 2^24 / e
  tmc_div #(
    .NW(CVW),
    .DW(EXP_W)
  ) u_cv_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cv_start),
    .num_i  ('0),
    .rem_i  (EXP_W'(33'h100_0000)),
    .den_i  (rom_rd),
    .done_o (cv_done),
    .quot_o (cv_quot)
  );

  // Means over the row count, one after the other
  tmc_div #(
    .NW(DNW),
    .DW(RCW)
  ) u_fin_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(fin_start),
    .num_i  (fin_num),
    .rem_i  ('0),
    .den_i  (rows_q),
    .done_o (fin_done),
    .quot_o (fin_quot)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = out_q;

  `TMC_ASSERT_IMP(a_no_write_in_pass, state_q == ST_CNT, !mem_we)
  `TMC_ASSERT_IMP(a_best_pos_clear, !bf_q, bpos_q == '0)
  `TMC_ASSERT_IMP(a_col_in_row, state_q == ST_IDLE, LW'(col_q) < len)
  `TMC_ASSERT_NXT(a_out_load, out_load, m_axis_tvalid)

endmodule
